>>> hw/rtl/grid_nearest_field_match_unit_macros.svh
// Assertion macros shared by the grid nearest field match RTL.
`ifndef GRID_NEAREST_FIELD_MATCH_UNIT_MACROS_SVH
`define GRID_NEAREST_FIELD_MATCH_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define GNFM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gnfm assertion failed");
`define GNFM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gnfm assertion failed");
`else
`define GNFM_ASSERT_SAME(label, ante, cons)
`define GNFM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> hw/rtl/gnfm_pkg.sv
// Types and fixed field widths of the grid nearest field match unit.
package gnfm_pkg;

    localparam int OFS_W       = 5;
    localparam int COMP_W      = 24;
    localparam int DIFF_W      = COMP_W + 1;
    localparam int DIST_W      = 50;
    localparam int REF_W       = 3 * COMP_W;
    localparam int S_TDATA_W   = 88;
    localparam int M_TDATA_W   = 64;
    localparam int STAGES      = 4;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } gnfm_state_t;

endpackage

>>> hw/rtl/gnfm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gnfm_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 625
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/grid_nearest_field_match_unit.sv
// Top level of the grid nearest field match unit: reference store, scan sequencer, distance pipe.
//
// Usage: the slave stream (s_*) carries two kinds of beat, chosen by s_tuser.
// A load beat (s_tuser = 0) writes one reference vector at grid offset
// (grid_x, grid_y); offsets outside -GRID_HALF..GRID_HALF are dropped. It gives
// no result. A query beat (s_tuser = 1) carries a sensor vector; the block
// reads all (2*GRID_HALF+1)^2 entries from the reference RAM, one per cycle,
// and returns the offsets and squared distance of the first nearest entry on
// the master stream (m_*). Every entry must be loaded before a query reads it.
// The scan uses the single RAM read port feeding one distance pipe; s_tready
// is low through the scan and until the result enters the output register.
// Loads are taken one per cycle while the block is idle.
// The result sits in an output register; the next beat is accepted while it
// waits, and a query finishing into a stalled output holds until it drains.
// Reset clears control state only; RAM contents are undefined until loaded.
module grid_nearest_field_match_unit #(
    parameter int GRID_HALF = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // grid_x, grid_y, comp_x, comp_y, comp_z, zero pad
    input  logic [gnfm_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // best_x, best_y, best_dist_sq, zero pad
    output logic [gnfm_pkg::M_TDATA_W-1:0] m_tdata
);

    import gnfm_pkg::*;

    `include "grid_nearest_field_match_unit_macros.svh"

    localparam int GRID_DIM = 2 * GRID_HALF + 1;
    localparam int CELLS    = GRID_DIM * GRID_DIM;
    localparam int AW       = $clog2(CELLS);
    localparam int IW       = $clog2(GRID_DIM);

    gnfm_state_t state_reg, state_next;

    logic [AW-1:0] addr_reg, addr_next;
    logic [IW-1:0] ix_reg, ix_next;
    logic [IW-1:0] iy_reg, iy_next;

    logic signed [COMP_W-1:0] sens_x_reg, sens_y_reg, sens_z_reg;

    logic              s_beat;
    logic              load_ok;
    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_waddr;
    logic [REF_W-1:0]  ram_rdata;
    logic              pipe_busy;
    logic              load_out;
    int                load_gx;
    int                load_gy;

    logic              pv_reg [1:STAGES];
    logic [IW-1:0]     pix_reg [1:STAGES];
    logic [IW-1:0]     piy_reg [1:STAGES];

    logic signed [DIFF_W-1:0] diff_x_reg, diff_y_reg, diff_z_reg;
    logic signed [DIST_W-1:0] sq_x, sq_y, sq_z;
    logic [DIST_W-1:0]        sq_x_reg, sq_y_reg, sq_z_reg;
    logic [DIST_W-1:0]        sum_reg;

    logic              have_reg;
    logic [DIST_W-1:0] best_reg;
    logic [IW-1:0]     bx_reg, by_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic signed [COMP_W-1:0] ref_x, ref_y, ref_z;

    assign s_beat  = s_tvalid & s_tready;
    assign load_gx = int'($signed(s_tdata[OFS_W-1:0]));
    assign load_gy = int'($signed(s_tdata[2*OFS_W-1:OFS_W]));
    assign load_ok = (load_gx >= -GRID_HALF) && (load_gx <= GRID_HALF)
                  && (load_gy >= -GRID_HALF) && (load_gy <= GRID_HALF);
    assign ram_waddr = AW'((load_gx + GRID_HALF) * GRID_DIM + (load_gy + GRID_HALF));
    assign ram_we    = s_beat && (s_tuser == REQ_LOAD) && load_ok;

    gnfm_ram #(
        .WIDTH (REF_W),
        .DEPTH (CELLS)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_tdata[2*OFS_W+REF_W-1:2*OFS_W]),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign pipe_busy = pv_reg[1] | pv_reg[2] | pv_reg[3] | pv_reg[4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            addr_reg      <= '0;
            ix_reg        <= '0;
            iy_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            ix_reg        <= ix_next;
            iy_reg        <= iy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        ix_next    = ix_reg;
        iy_next    = iy_reg;
        s_tready   = 1'b0;
        ram_re     = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid && (s_tuser == REQ_QUERY))
                begin
                    addr_next  = '0;
                    ix_next    = '0;
                    iy_next    = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ram_re    = 1'b1;
                addr_next = addr_reg + AW'(1);
                if (iy_reg == IW'(GRID_DIM - 1))
                begin
                    iy_next = '0;
                    ix_next = ix_reg + IW'(1);
                end
                else
                begin
                    iy_next = iy_reg + IW'(1);
                end
                if (addr_reg == AW'(CELLS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!pipe_busy && (!out_valid_reg || m_tready))
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = load_out | (out_valid_reg & ~m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= STAGES; i++)
            begin
                pv_reg[i] <= 1'b0;
            end
            have_reg <= 1'b0;
        end
        else
        begin
            pv_reg[1] <= ram_re;
            for (int i = 2; i <= STAGES; i++)
            begin
                pv_reg[i] <= pv_reg[i-1];
            end
            if (s_beat && (s_tuser == REQ_QUERY))
            begin
                have_reg <= 1'b0;
            end
            else if (pv_reg[STAGES])
            begin
                have_reg <= 1'b1;
            end
        end
    end

    assign ref_x = $signed(ram_rdata[COMP_W-1:0]);
    assign ref_y = $signed(ram_rdata[2*COMP_W-1:COMP_W]);
    assign ref_z = $signed(ram_rdata[3*COMP_W-1:2*COMP_W]);

    assign sq_x = diff_x_reg * diff_x_reg;
    assign sq_y = diff_y_reg * diff_y_reg;
    assign sq_z = diff_z_reg * diff_z_reg;

    always_ff @(posedge clk)
    begin
        if (s_beat && (s_tuser == REQ_QUERY))
        begin
            sens_x_reg <= $signed(s_tdata[2*OFS_W+COMP_W-1:2*OFS_W]);
            sens_y_reg <= $signed(s_tdata[2*OFS_W+2*COMP_W-1:2*OFS_W+COMP_W]);
            sens_z_reg <= $signed(s_tdata[2*OFS_W+3*COMP_W-1:2*OFS_W+2*COMP_W]);
        end
        pix_reg[1] <= ix_reg;
        piy_reg[1] <= iy_reg;
        for (int i = 2; i <= STAGES; i++)
        begin
            pix_reg[i] <= pix_reg[i-1];
            piy_reg[i] <= piy_reg[i-1];
        end
        diff_x_reg <= DIFF_W'(ref_x) - DIFF_W'(sens_x_reg);
        diff_y_reg <= DIFF_W'(ref_y) - DIFF_W'(sens_y_reg);
        diff_z_reg <= DIFF_W'(ref_z) - DIFF_W'(sens_z_reg);
        sq_x_reg   <= sq_x;
        sq_y_reg   <= sq_y;
        sq_z_reg   <= sq_z;
        sum_reg    <= sq_x_reg + sq_y_reg + sq_z_reg;
        if (pv_reg[STAGES] && (!have_reg || (sum_reg < best_reg)))
        begin
            best_reg <= sum_reg;
            bx_reg   <= pix_reg[STAGES];
            by_reg   <= piy_reg[STAGES];
        end
        if (load_out)
        begin
            out_data_reg <= {
                (M_TDATA_W - 2 * OFS_W - DIST_W)'(0),
                best_reg,
                OFS_W'(int'(by_reg) - GRID_HALF),
                OFS_W'(int'(bx_reg) - GRID_HALF)
            };
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `GNFM_ASSERT_SAME(a_pipe_in_query, pipe_busy, (state_reg == ST_SCAN) || (state_reg == ST_DRAIN))
    `GNFM_ASSERT_SAME(a_scan_addr_in_range, state_reg == ST_SCAN, addr_reg <= AW'(CELLS - 1))
    `GNFM_ASSERT_NEXT(a_result_after_drain, load_out, m_tvalid && have_reg && (state_reg == ST_IDLE))
    `GNFM_ASSERT_SAME(a_no_write_in_scan, state_reg != ST_IDLE, !ram_we)

endmodule
